// ===== sv/tsvp_pkg.sv =====
// Package for the tempo-synced volume pattern unit.
// Holds default sizes, pattern and register codes, control structs and the pump curve builder.
// No dependencies.
package tsvp_pkg;

    // Default sizes handed to the top level parameters.
    localparam int SAMPLE_BITS_DEF      = 24;
    localparam int PHASE_FRAC_BITS_DEF  = 24;
    localparam int GAIN_FRAC_BITS_DEF   = 15;
    localparam int CURVE_TABLE_BITS_DEF = 8;

    // Width of one gain digit handled per multiplier step.
    localparam int DIGIT_BITS = 4;

    // Dip depth 0.7 in Q0.16, truncated.
    localparam int DIP_DEPTH_BITS = 16;
    localparam logic [DIP_DEPTH_BITS-1:0] DIP_DEPTH = 16'd45875;

    // Configuration register file layout.
    localparam int MODE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_MODE = 1'b0,
        REG_PHASE_STEP   = 1'b1
    } cfg_reg_t;

    // Pattern codes; code 7 is unused and behaves as unity gain.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFF       = 3'd0,
        MODE_HALF      = 3'd1,
        MODE_EIGHTH    = 3'd2,
        MODE_SIXTEENTH = 3'd3,
        MODE_TRIPLET   = 3'd4,
        MODE_PUMP      = 3'd5,
        MODE_DIP       = 3'd6
    } mode_t;

    // Control from the sequencer to the serial multiplier.
    typedef struct packed {
        logic start;
        logic step;
    } mul_ctl_t;

    // One entry of the pump curve: gain = 1 - exp(-4k/2^c), rounded to Q1.g.
    // Evaluated at elaboration only; the series has fixed divisors.
    function automatic logic [31:0] pump_entry(int k, int c, int g);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] one;
        y    = 64'(k) << (29 - c);
        one  = 64'd1 << 31;
        term = one;
        sum  = one;
        term = ((term * y) >> 31) / 1;   sum = sum - term;
        term = ((term * y) >> 31) / 2;   sum = sum + term;
        term = ((term * y) >> 31) / 3;   sum = sum - term;
        term = ((term * y) >> 31) / 4;   sum = sum + term;
        term = ((term * y) >> 31) / 5;   sum = sum - term;
        term = ((term * y) >> 31) / 6;   sum = sum + term;
        term = ((term * y) >> 31) / 7;   sum = sum - term;
        term = ((term * y) >> 31) / 8;   sum = sum + term;
        term = ((term * y) >> 31) / 9;   sum = sum - term;
        term = ((term * y) >> 31) / 10;  sum = sum + term;
        e = sum;
        // Raise to the 16th power by four squarings.
        e = (e * e) >> 31;
        e = (e * e) >> 31;
        e = (e * e) >> 31;
        e = (e * e) >> 31;
        if (e > one)
        begin
            e = one;
        end
        return 32'((one - e + (64'd1 << (30 - g))) >> (31 - g));
    endfunction

endpackage

// ===== sv/tsvp_channels.sv =====
// Stream channel interfaces for the sample request and the result request.
// Depends on tsvp_pkg for the default sample width.
interface tsvp_item_if #(
    parameter int SAMPLE_BITS = tsvp_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface tsvp_result_if #(
    parameter int SAMPLE_BITS = tsvp_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== sv/tsvp_gain.sv =====
// Two-stage gain pipeline: pattern gain from the current mode and beat phase.
// Depends on tsvp_pkg for pattern codes, dip depth and the pump curve builder.
module tsvp_gain #(
    parameter int PHASE_FRAC_BITS  = tsvp_pkg::PHASE_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS   = tsvp_pkg::GAIN_FRAC_BITS_DEF,
    parameter int CURVE_TABLE_BITS = tsvp_pkg::CURVE_TABLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tsvp_pkg::MODE_BITS-1:0] mode,
    input  logic [PHASE_FRAC_BITS:0]      phase,
    input  logic                          flush,
    output logic [GAIN_FRAC_BITS:0]       gain,
    output logic                          gain_ok
);

    localparam int F           = PHASE_FRAC_BITS;
    localparam int G           = GAIN_FRAC_BITS;
    localparam int C           = CURVE_TABLE_BITS;
    localparam int CURVE_DEPTH = 1 << C;
    localparam int SQ_W        = 2 * F;
    localparam int DP_W        = F + tsvp_pkg::DIP_DEPTH_BITS;
    localparam logic [G:0] GAIN_ONE = {1'b1, {G{1'b0}}};

    logic [G:0]        curve_rom [CURVE_DEPTH];
    logic [F-1:0]      frac;
    logic [SQ_W-1:0]   frac_wide;
    logic [SQ_W-1:0]   sq_prod;
    logic [F+1:0]      trip_sum;
    logic              gate_on;
    logic [DP_W-1:0]   dip_prod;
    logic [G-1:0]      dip_drop;
    logic [G:0]        gain_next;

    tsvp_pkg::mode_t   mode1_reg;
    logic              gate1_reg;
    logic [G:0]        curve1_reg;
    logic [F-1:0]      sq1_reg;
    logic              ok1_reg;
    logic [G:0]        gain_reg;
    logic              ok2_reg;

    // Pump curve built at elaboration.
    for (genvar k = 0; k < CURVE_DEPTH; k++)
    begin : g_curve
        localparam logic [G:0] ENTRY = (G + 1)'(tsvp_pkg::pump_entry(k, C, G));
        assign curve_rom[k] = ENTRY;
    end

    // Stage one: gate decisions, curve lookup and the phase square.
    assign frac      = phase[F-1:0];
    assign frac_wide = SQ_W'(frac);
    assign sq_prod   = frac_wide * frac_wide;
    assign trip_sum  = {1'b0, frac, 1'b0} + {2'b00, frac};

    always_comb
    begin
        unique case (tsvp_pkg::mode_t'(mode))
            tsvp_pkg::MODE_HALF:      gate_on = ~phase[F];
            tsvp_pkg::MODE_EIGHTH:    gate_on = ~phase[F-2];
            tsvp_pkg::MODE_SIXTEENTH: gate_on = ~phase[F-3];
            tsvp_pkg::MODE_TRIPLET:   gate_on = ~trip_sum[F-1];
            default:                  gate_on = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mode1_reg  <= tsvp_pkg::mode_t'(mode);
        gate1_reg  <= gate_on;
        curve1_reg <= curve_rom[frac[F-1 -: C]];
        sq1_reg    <= sq_prod[SQ_W-1:F];
    end

    // Stage two: dip depth and final gain selection.
    assign dip_prod = DP_W'(sq1_reg) * DP_W'(tsvp_pkg::DIP_DEPTH);
    assign dip_drop = dip_prod[DP_W-1 -: G];

    always_comb
    begin
        unique case (mode1_reg)
            tsvp_pkg::MODE_HALF,
            tsvp_pkg::MODE_EIGHTH,
            tsvp_pkg::MODE_SIXTEENTH,
            tsvp_pkg::MODE_TRIPLET:   gain_next = gate1_reg ? GAIN_ONE : '0;
            tsvp_pkg::MODE_PUMP:      gain_next = curve1_reg;
            tsvp_pkg::MODE_DIP:       gain_next = GAIN_ONE - {1'b0, dip_drop};
            default:                  gain_next = GAIN_ONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
    end

    // The gain is trusted once both stages have seen unchanged inputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok1_reg <= 1'b0;
            ok2_reg <= 1'b0;
        end
        else
        begin
            ok1_reg <= ~flush;
            ok2_reg <= ok1_reg & ~flush;
        end
    end

    assign gain    = gain_reg;
    assign gain_ok = ok2_reg;

endmodule

// ===== sv/tsvp_serial_mul.sv =====
// Digit-serial signed-by-unsigned multiplier, one gain digit per cycle while ctl.step is high, LSB first.
// Depends on tsvp_pkg for the digit width and the control struct.
module tsvp_serial_mul #(
    parameter int SAMPLE_BITS    = tsvp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = tsvp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsvp_pkg::mul_ctl_t            ctl,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic [GAIN_FRAC_BITS:0]       gain,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          last
);

    localparam int S      = SAMPLE_BITS;
    localparam int G      = GAIN_FRAC_BITS;
    localparam int D      = tsvp_pkg::DIGIT_BITS;
    localparam int N      = (G + 1 + D - 1) / D;
    localparam int CNT_W  = $clog2(N);
    localparam int SUM_W  = S + D + 1;
    localparam int LOW_W  = N * D;
    localparam int PROD_W = SUM_W + LOW_W - D;

    logic signed [S-1:0]     x_reg;
    logic [LOW_W-1:0]        dig_reg;
    logic signed [S:0]       acc_reg;
    logic [LOW_W-1:0]        low_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [SUM_W-1:0] x_wide;
    logic signed [SUM_W-1:0] d_wide;
    logic signed [SUM_W-1:0] acc_wide;
    logic signed [SUM_W-1:0] pp;
    logic signed [SUM_W-1:0] sum;
    logic [PROD_W-1:0]       prod_full;

    // One partial product and accumulate per step.
    assign x_wide   = {{(SUM_W - S){x_reg[S-1]}}, x_reg};
    assign d_wide   = {{(SUM_W - D){1'b0}}, dig_reg[D-1:0]};
    assign acc_wide = {{(SUM_W - S - 1){acc_reg[S]}}, acc_reg};
    assign pp       = x_wide * d_wide;
    assign sum      = acc_wide + pp;

    // Full product as it stands after the final step; floor shift by the gain scale.
    assign prod_full = {sum, low_reg[LOW_W-1:D]};
    assign result    = prod_full[G +: S];
    assign last      = (cnt_reg == CNT_W'(N - 1));

    // Operand and accumulator shift registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg   <= x;
            dig_reg <= LOW_W'(gain);
            acc_reg <= '0;
            low_reg <= '0;
        end
        else if (ctl.step)
        begin
            dig_reg <= dig_reg >> D;
            acc_reg <= sum[SUM_W-1:D];
            low_reg <= {sum[D-1:0], low_reg[LOW_W-1:D]};
        end
    end

    // Digit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.start)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

// ===== sv/tempo_synced_volume_pattern_unit.sv =====
// Each request carries one signed sample; the result is the sample times a pattern gain
// (Q1.GAIN_FRAC_BITS, floor shift), and the beat phase then advances by phase_step unless the
// mode is off. The digit-serial multiplier consumes four gain bits per cycle while a sample runs;
// back-to-back requests are taken on the multiplier's last step while the result side keeps up.
// The gain comes from a two-stage pipeline on the phase, so after reset or a register write no
// request is taken until both stages hold the new inputs (gain_ok). A finished result waits in
// the output register while the next sample runs.
// Depends on tsvp_pkg, tsvp_channels, tsvp_gain and tsvp_serial_mul.
module tempo_synced_volume_pattern_unit #(
    parameter int SAMPLE_BITS      = tsvp_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS  = tsvp_pkg::PHASE_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS   = tsvp_pkg::GAIN_FRAC_BITS_DEF,
    parameter int CURVE_TABLE_BITS = tsvp_pkg::CURVE_TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tsvp_item_if.sink                          item,
    tsvp_result_if.source                      result,
    input  logic                               cfg_wr_en,
    input  logic [tsvp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PHASE_FRAC_BITS-1:0]         cfg_data
);

    localparam int F = PHASE_FRAC_BITS;
    localparam logic [F-1:0] STEP_RESET = F'(699);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MUL  = 2'b10
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [tsvp_pkg::MODE_BITS-1:0] mode_reg;
    logic [F-1:0]                   step_reg;
    logic [F:0]                     phase_reg;
    logic [F:0]                     phase_next;
    logic                           item_last_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_sample_reg;
    logic                           out_last_reg;

    logic                           can_finish;
    logic                           finish;
    logic                           accept;
    logic                           gain_ok;
    logic [GAIN_FRAC_BITS:0]        gain;
    logic                           mul_last;
    logic signed [SAMPLE_BITS-1:0]  mul_result;
    tsvp_pkg::mul_ctl_t             mul_ctl;

    // Gain pipeline, restarted whenever the phase or a register changes.
    tsvp_gain #(
        .PHASE_FRAC_BITS  (PHASE_FRAC_BITS),
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
        .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
    ) u_gain (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .phase   (phase_reg),
        .flush   (accept | cfg_wr_en),
        .gain    (gain),
        .gain_ok (gain_ok)
    );

    tsvp_serial_mul #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .x      (item.sample_in),
        .gain   (gain),
        .result (mul_result),
        .last   (mul_last)
    );

    // Handshake and sequencing.
    assign can_finish = ~out_valid_reg | result.ready;
    assign finish     = (state_reg == ST_MUL) & mul_last & can_finish;
    assign item.ready = gain_ok & ((state_reg == ST_IDLE) | finish);
    assign accept     = item.valid & item.ready;

    assign mul_ctl.start = accept;
    assign mul_ctl.step  = (state_reg == ST_MUL) & ~mul_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (finish && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Beat phase advances once per sample outside off mode, wrapping at two beats.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && (mode_reg != tsvp_pkg::MODE_OFF))
        begin
            phase_next = phase_reg + {1'b0, step_reg};
        end
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= tsvp_pkg::MODE_OFF;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (tsvp_pkg::cfg_reg_t'(cfg_index))
                    tsvp_pkg::REG_PATTERN_MODE: mode_reg <= cfg_data[tsvp_pkg::MODE_BITS-1:0];
                    tsvp_pkg::REG_PHASE_STEP:   step_reg <= cfg_data;
                    default:                    mode_reg <= mode_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_last_reg <= item.last_in;
        end
        if (finish)
        begin
            out_sample_reg <= mul_result;
            out_last_reg   <= item_last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.last_out   = out_last_reg;

endmodule

// ===== tb/tsvp_gate_check_pkg.sv =====
// Scoreboard for the tempo-synced volume pattern unit: gain predictor and expected sample queue.
// Depends on tsvp_pkg for sizes, pattern codes and register indexes.
package tsvp_gate_check_pkg;
    import tsvp_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int PF = PHASE_FRAC_BITS_DEF;
    localparam int GF = GAIN_FRAC_BITS_DEF;
    localparam int CT = CURVE_TABLE_BITS_DEF;

    // Code 7 has no name in the pattern enum; it must act as unity gain.
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 3'd7;
    localparam logic [PF-1:0] STEP_AT_RESET = 24'd699;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 last;
    } gated_sample_t;

    class gated_sample_checker;
        logic [MODE_BITS-1:0] mode;
        logic [PF-1:0]        step;
        logic [PF:0]          phase;
        logic [GF:0]          pump_gain [2**CT];
        gated_sample_t        gated_samples_due [$];
        int unsigned          samples_noted;
        int unsigned          outputs_checked;
        int unsigned          mismatches;

        // Build the pump curve: 1 - exp(-4k/2^CT), exp from a ten-term series raised to the 16th.
        function new();
            logic [63:0] unit;
            logic [63:0] y;
            logic [63:0] term;
            logic [63:0] series;
            logic [63:0] e;
            logic [63:0] scaled;
            unit            = 64'd1 << 31;
            mode            = MODE_OFF;
            step            = STEP_AT_RESET;
            phase           = '0;
            samples_noted   = 0;
            outputs_checked = 0;
            mismatches      = 0;
            for (int k = 0; k < 2**CT; k++)
            begin
                y      = 64'(k) << (29 - CT);
                term   = unit;
                series = unit;
                for (int n = 1; n <= 10; n++)
                begin
                    term   = ((term * y) >> 31) / 64'(n);
                    series = (n % 2 == 1) ? series - term : series + term;
                end
                e = series;
                repeat (4) e = (e * e) >> 31;
                if (e > unit)
                begin
                    e = unit;
                end
                scaled       = (unit - e + (64'd1 << (30 - GF))) >> (31 - GF);
                pump_gain[k] = scaled[GF:0];
            end
        endfunction

        function void apply_register(cfg_reg_t idx, logic [PF-1:0] data);
            if (idx == REG_PATTERN_MODE)
            begin
                mode = data[MODE_BITS-1:0];
            end
            else
            begin
                step = data;
            end
        endfunction

        // Gain in Q1.GF for the current pattern at the current beat phase.
        function logic [GF:0] pattern_gain();
            logic [PF-1:0] frac;
            logic [PF-1:0] thirds;
            logic [63:0]   square;
            logic [63:0]   dip;
            logic [GF:0]   unity;
            unity     = '0;
            unity[GF] = 1'b1;
            frac      = phase[PF-1:0];
            thirds    = frac * 2'd3;
            case (mode)
                MODE_HALF:      return phase[PF] ? '0 : unity;
                MODE_EIGHTH:    return phase[PF-2] ? '0 : unity;
                MODE_SIXTEENTH: return phase[PF-3] ? '0 : unity;
                MODE_TRIPLET:   return thirds[PF-1] ? '0 : unity;
                MODE_PUMP:      return pump_gain[frac[PF-1 -: CT]];
                MODE_DIP:
                begin
                    square = (64'(frac) * 64'(frac)) >> PF;
                    dip    = (square * 64'(DIP_DEPTH)) >> (PF + DIP_DEPTH_BITS - GF);
                    return unity - dip[GF:0];
                end
                default:        return unity;
            endcase
        endfunction

        // An accepted request: scale the sample and advance the beat unless the mode is off.
        function void note_sample(logic signed [SW-1:0] sample, logic last);
            gated_sample_t due;
            longint        product;
            due.last = last;
            if (mode == MODE_OFF)
            begin
                due.sample = sample;
            end
            else
            begin
                product    = longint'(sample) * longint'(pattern_gain());
                product    = product >>> GF;
                due.sample = product[SW-1:0];
                phase      = phase + step;
            end
            gated_samples_due.push_back(due);
            samples_noted++;
        endfunction

        function void report_error(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: %s", msg);
            end
        endfunction

        // An accepted result is compared with the oldest expected sample.
        function void check_output(logic signed [SW-1:0] sample, logic last);
            gated_sample_t due;
            outputs_checked++;
            if (gated_samples_due.size() == 0)
            begin
                report_error($sformatf("result %0d/%0b with no request pending", sample, last));
                return;
            end
            due = gated_samples_due.pop_front();
            if (due.sample !== sample || due.last !== last)
            begin
                report_error($sformatf("result %0d: expected sample %0d last %0b, got %0d last %0b",
                                       outputs_checked, due.sample, due.last, sample, last));
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench: drives sample requests with bursts and gaps, stalls the result side,
// walks all pattern codes and a range of phase steps, and checks every result. Depends on tsvp_pkg,
// tsvp_channels, tsvp_gate_check_pkg and the unit itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsvp_pkg::*;
    import tsvp_gate_check_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RUN_LIMIT     = 400000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 63;
    localparam int SETTLE_CYCLES = 4;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_wr_en;
    cfg_reg_t      cfg_index;
    logic [PF-1:0] cfg_data;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left;

    gated_sample_checker gates;

    tsvp_item_if   #(.SAMPLE_BITS(SW)) item_ch ();
    tsvp_result_if #(.SAMPLE_BITS(SW)) result_ch ();

    tempo_synced_volume_pattern_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Note accepted requests and check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                gates.note_sample(item_ch.sample_in, item_ch.last_in);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                gates.check_output(result_ch.sample_out, result_ch.last_out);
            end
        end
    end

    // Result side: stretches of always-ready, random and mostly stalled, plus one long hold.
    initial
    begin
        int span;
        int style;
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && gates.samples_noted >= HOLD_AT)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            span  = $urandom_range(40, 1);
            style = $urandom_range(2, 0);
            repeat (span)
            begin
                case (style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(1, 0));
                    default: result_ch.ready <= ($urandom_range(3, 0) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until accepted; close a burst with a random gap.
    task automatic send_sample(logic signed [SW-1:0] sample, logic last);
        int gap;
        item_ch.valid     <= 1'b1;
        item_ch.sample_in <= sample;
        item_ch.last_in   <= last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(12, 1);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(30, 0);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Registers change only once every result is out and the unit has settled.
    task automatic write_register(cfg_reg_t idx, logic [PF-1:0] data);
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (gates.gated_samples_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        gates.apply_register(idx, data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        int kind;
        kind = $urandom_range(9, 0);
        case (kind)
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return SW'($urandom_range(511, 0)) - SW'(256);
            default: return SW'($urandom());
        endcase
    endfunction

    // Stimulus: reset, a directed pass over every pattern, then random phases.
    initial
    begin
        logic [MODE_BITS-1:0] patterns [8];
        logic [PF-1:0]        step;
        int                   choice;
        patterns = '{MODE_OFF, MODE_HALF, MODE_EIGHTH, MODE_SIXTEENTH,
                     MODE_TRIPLET, MODE_PUMP, MODE_DIP, MODE_SPARE};
        gates = new();
        burst_left = $urandom_range(30, 0);
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.sample_in <= '0;
        item_ch.last_in   <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_PATTERN_MODE;
        cfg_data          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: gate off, sample extremes pass unchanged.
        send_sample({1'b0, {(SW-1){1'b1}}}, 1'b0);
        send_sample({1'b1, {(SW-1){1'b0}}}, 1'b1);
        send_sample('1, 1'b0);

        // Every pattern code with a step that wraps the beat several times.
        write_register(REG_PHASE_STEP, 24'h555555);
        for (int p = 1; p < 8; p++)
        begin
            write_register(REG_PATTERN_MODE, PF'(patterns[p]));
            send_sample({1'b0, {(SW-1){1'b1}}}, 1'b1);
            send_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
            send_sample(random_sample(), 1'($urandom_range(1, 0)));
        end

        // Random phases: each pattern once, then random ones; zero and full-scale steps first.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            choice = $urandom_range(2, 0);
            if (ph == 0)
            begin
                step = '0;
            end
            else if (ph == 1)
            begin
                step = '1;
            end
            else if (choice == 0)
            begin
                step = PF'($urandom_range(1 << 16, 1));
            end
            else
            begin
                step = PF'($urandom_range((1 << PF) - 1, 1 << 18));
            end
            write_register(REG_PHASE_STEP, step);
            write_register(REG_PATTERN_MODE,
                           PF'(ph < 8 ? patterns[ph] : patterns[$urandom_range(7, 0)]));
            repeat (PHASE_ITEMS)
            begin
                send_sample(random_sample(), ($urandom_range(7, 0) == 0));
            end
        end

        // Drain and leave room for any stray result.
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (gates.gated_samples_due.size() != 0);
        repeat (3 * SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d gated samples over all eight pattern codes and %0d random phases,",
                 gates.outputs_checked, RANDOM_PHASES);
        $display("with phase steps from zero to full scale and one %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (gates.mismatches == 0 && gates.gated_samples_due.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
